// ----- src/cptg_pkg.sv -----
// Shared types and constants for the counted pulse train generator.
// No dependencies; imported by every module of the block.
package cptg_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PHASE_W   = 33;
  localparam int unsigned CFG_IDX_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_WIDTH   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BURST_COUNT = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_VALUE = 4'd3;

  localparam logic [DATA_W-1:0] LEVEL_RESET = 32'd1;

  typedef struct packed {
    logic [DATA_W-1:0] high_width;
    logic [DATA_W-1:0] low_width;
    logic [DATA_W-1:0] burst_count;
    logic [DATA_W-1:0] level_value;
  } cfg_t;

  typedef struct packed {
    logic [DATA_W-1:0] pin_value;
    logic [DATA_W-1:0] pulses_left;
    logic              finished;
    logic              running;
  } result_t;

endpackage

// ----- src/counted_pulse_train_generator_top.sv -----
// Counted pulse train generator: one result word for every input word.
// The input word passes through the input register, then the result register.
// Throughput: one word per cycle unless the result stalls; cptg_core closes its state loop.
// A stalled result holds the input register; the input stalls only when both are full.
// Synchronous active-high reset clears the generator state, empties both registers,
// and loads the configuration defaults (level value 1, all others 0).
module counted_pulse_train_generator_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           tick,
  input  logic                           start_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cptg_pkg::DATA_W-1:0]    pin_value,
  output logic [cptg_pkg::DATA_W-1:0]    pulses_left,
  output logic                           finished,
  output logic                           running,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cptg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cptg_pkg::DATA_W-1:0]    cfg_data
);
  import cptg_pkg::*;

  cfg_t    cfg;
  result_t result;
  logic    s1_valid;
  logic    s1_tick;
  logic    s1_start;
  logic    advance;

  cptg_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // pipeline flow control
  assign advance  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_tick  <= tick;
      s1_start <= start_req;
    end
  end

  cptg_core u_core (
    .clk       (clk),
    .rst       (rst),
    .advance   (advance),
    .tick      (s1_tick),
    .start_req (s1_start),
    .cfg       (cfg),
    .result    (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pin_value   <= result.pin_value;
      pulses_left <= result.pulses_left;
      finished    <= result.finished;
      running     <= result.running;
    end
  end

endmodule

// ----- src/cptg_cfg.sv -----
// Configuration register file for the counted pulse train generator.
// Depends on cptg_pkg for register indexes and the cfg_t bundle.
module cptg_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cptg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cptg_pkg::DATA_W-1:0]    cfg_data,
  output cptg_pkg::cfg_t                 cfg
);
  import cptg_pkg::*;

  // writes are always taken
  assign cfg_ready = 1'b1;

  // register writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.high_width  <= '0;
      cfg.low_width   <= '0;
      cfg.burst_count <= '0;
      cfg.level_value <= LEVEL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HIGH_WIDTH:  cfg.high_width  <= cfg_data;
        REG_LOW_WIDTH:   cfg.low_width   <= cfg_data;
        REG_BURST_COUNT: cfg.burst_count <= cfg_data;
        REG_LEVEL_VALUE: cfg.level_value <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// ----- src/cptg_core.sv -----
// Generator state (phase, completed periods, run flag, pin) and its
// update for one word. Depends on cptg_pkg.
module cptg_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              advance,
  input  logic              tick,
  input  logic              start_req,
  input  cptg_pkg::cfg_t    cfg,
  output cptg_pkg::result_t result
);
  import cptg_pkg::*;

  logic [PHASE_W-1:0] phase_count, phase_count_next;
  logic [DATA_W-1:0]  periods_done, periods_done_next;
  logic               active_flag, active_flag_next;
  logic [DATA_W-1:0]  pin_register, pin_register_next;

  logic [PHASE_W-1:0] period;
  logic [PHASE_W-1:0] half;
  logic [PHASE_W-1:0] phase_inc;
  logic               period_zero;
  logic               tick_go;
  logic               eval_do;
  logic               above_half;
  logic [DATA_W-1:0]  diff;
  logic [DATA_W-1:0]  remain;
  logic               done;

  // period and its half
  assign period      = {1'b0, cfg.high_width} + {1'b0, cfg.low_width};
  assign half        = period >> 1;
  assign period_zero = (period == '0);
  assign tick_go     = tick && active_flag && !period_zero;
  assign phase_inc   = phase_count + {{(PHASE_W-1){1'b0}}, 1'b1};

  // phase and period bookkeeping
  always_comb begin
    phase_count_next  = phase_count;
    periods_done_next = periods_done;
    if (start_req) begin
      phase_count_next  = '0;
      periods_done_next = '0;
    end else if (tick_go) begin
      if (phase_inc >= period) begin
        phase_count_next = '0;
        if (periods_done != {DATA_W{1'b1}}) begin
          periods_done_next = periods_done + {{(DATA_W-1){1'b0}}, 1'b1};
        end
      end else begin
        phase_count_next = phase_inc;
      end
    end
  end

  // remaining pulses from the updated state
  assign above_half = phase_count_next > half;
  assign diff       = cfg.burst_count - periods_done_next;
  always_comb begin
    if (cfg.burst_count == '0 || periods_done_next >= cfg.burst_count) begin
      remain = '0;
    end else begin
      remain = diff - {{(DATA_W-1){1'b0}}, above_half};
    end
  end
  assign done    = (cfg.burst_count != '0) && (remain == '0);
  assign eval_do = (start_req || tick_go) && !period_zero;

  // pin level and run flag
  always_comb begin
    pin_register_next = pin_register;
    active_flag_next  = start_req ? 1'b1 : active_flag;
    if (eval_do) begin
      if (done) begin
        pin_register_next = '0;
        active_flag_next  = 1'b0;
      end else if (phase_count_next < {1'b0, cfg.high_width}) begin
        if (pin_register == '0) begin
          pin_register_next = cfg.level_value;
        end
      end else begin
        pin_register_next = '0;
      end
    end
  end

  // result word for this item
  assign result.pin_value   = pin_register_next;
  assign result.pulses_left = active_flag_next ? remain : '0;
  assign result.finished    = eval_do && done;
  assign result.running     = active_flag_next;

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count  <= '0;
      periods_done <= '0;
      active_flag  <= 1'b0;
      pin_register <= '0;
    end else if (advance) begin
      phase_count  <= phase_count_next;
      periods_done <= periods_done_next;
      active_flag  <= active_flag_next;
      pin_register <= pin_register_next;
    end
  end

endmodule

// ----- src/cptg_checker.sv -----
// Port-level checks for the counted pulse train generator, bound to the top level.
// Depends on cptg_pkg for widths.
module cptg_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [cptg_pkg::DATA_W-1:0] pin_value,
  input logic [cptg_pkg::DATA_W-1:0] pulses_left,
  input logic                        finished,
  input logic                        running
);
  import cptg_pkg::*;

  // a finished burst leaves the pin low and the generator stopped
  a_finish_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> !running && pin_value == '0 && pulses_left == '0)
    else $error("finished word without stop");

  // a stopped generator reports no pulses left
  a_idle_no_pulses: assert property (@(posedge clk) disable iff (rst)
    out_valid && !running |-> pulses_left == '0)
    else $error("pulses left while stopped");

  // input backpressure only comes from a held result word
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // a stalled result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(pin_value) && $stable(pulses_left)
      && $stable(finished) && $stable(running))
    else $error("stalled result word changed");

endmodule

bind counted_pulse_train_generator_top cptg_checker u_cptg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .pin_value   (pin_value),
  .pulses_left (pulses_left),
  .finished    (finished),
  .running     (running)
);
